[hw/rtl/mexp_pkg.sv]
package mexp_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH);
    localparam int CFG_IDX_W  = 2;

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    localparam t_cfg_idx CFG_EXPONENT = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_MODULUS  = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_DECRYPT  = t_cfg_idx'(2);

    // One step of a bit-serial modular multiply: (2p + addend) mod m, for p and addend below m.
    // The sum stays below 3m, so one of three candidates is the answer.
    function automatic t_word mod_step(t_word p, t_word addend, t_word m);
        logic [WORD_WIDTH+2:0] t;
        logic [WORD_WIDTH+2:0] d1;
        logic [WORD_WIDTH+2:0] d2;
        t_word                 res;
        t   = {2'b00, p, 1'b0} + {3'b000, addend};
        d1  = t - {3'b000, m};
        d2  = t - {2'b00, m, 1'b0};
        if (!d2[WORD_WIDTH+2]) begin
            res = d2[WORD_WIDTH-1:0];
        end else if (!d1[WORD_WIDTH+2]) begin
            res = d1[WORD_WIDTH-1:0];
        end else begin
            res = t[WORD_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/modular_exponentiation.sv]
// Computes value^exponent mod modulus for each input word by right-to-left square-and-multiply,
// with exponent, modulus and decrypt mode held in configuration registers, which are to be
// written only while the block is idle; the user is bound to this, as the block itself does not
// enforce it. All arithmetic is bit-serial: the input is first reduced mod modulus one bit per
// cycle, then each exponent bit takes one pass in which two shift-and-add modular multipliers
// run side by side, one squaring the base and one multiplying the running result. Processing
// stops after the highest set exponent bit; a zero exponent or a zero modulus finishes after the
// reduction or at once. A zero modulus yields 0. In decrypt mode only the low 8 bits of the
// result are returned. The result sits in an output register, so a new word is taken while the
// previous result still waits to be read.
module modular_exponentiation (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  mexp_pkg::t_word           i_s_axis_tdata,  // [31:0] value
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output mexp_pkg::t_word           o_m_axis_tdata,  // [31:0] power
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  mexp_pkg::t_cfg_idx        i_cfg_index,
    input  mexp_pkg::t_word           i_cfg_data
);
    import mexp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_EXP,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    t_word              r_exp_sh;
    t_word              r_mul_sh;
    t_word              r_acc;
    t_word              r_base;
    t_word              r_p1;
    t_word              r_p2;
    t_word              r_mod;
    logic               r_dec;
    logic               r_out_valid;
    t_word              r_out_data;

    t_word              r_cfg_exp;
    t_word              r_cfg_mod;
    logic               r_cfg_dec;

    t_word              n_p1;
    t_word              n_p2;
    logic               mul_bit;
    logic               last_cnt;
    logic               in_accept;
    logic               out_load;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load  = (r_state == S_FINISH) && (!r_out_valid || i_m_axis_tready);
    assign mul_bit   = r_mul_sh[WORD_WIDTH-1];
    assign last_cnt  = (r_cnt == CNT_W'(WORD_WIDTH - 1));

    // In reduction the second unit shifts the value in bit by bit; in exponentiation both units
    // take the multiplier bits of the current base, most significant first.
    always_comb begin
        n_p1 = mod_step(r_p1, mul_bit ? r_acc : '0, r_mod);
        if (r_state == S_REDUCE) begin
            n_p2 = mod_step(r_p2, {{(WORD_WIDTH-1){1'b0}}, mul_bit}, r_mod);
        end else begin
            n_p2 = mod_step(r_p2, mul_bit ? r_base : '0, r_mod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_exp <= '0;
            r_cfg_mod <= t_word'(1);
            r_cfg_dec <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EXPONENT: r_cfg_exp <= i_cfg_data;
                CFG_MODULUS:  r_cfg_mod <= i_cfg_data;
                CFG_DECRYPT:  r_cfg_dec <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_mul_sh <= i_s_axis_tdata;
                        r_exp_sh <= r_cfg_exp;
                        r_mod    <= r_cfg_mod;
                        r_dec    <= r_cfg_dec;
                        r_p1     <= '0;
                        r_p2     <= '0;
                        r_cnt    <= '0;
                        if (r_cfg_mod == '0) begin
                            r_acc   <= '0;
                            r_state <= S_FINISH;
                        end else begin
                            r_acc   <= (r_cfg_mod == t_word'(1)) ? '0 : t_word'(1);
                            r_state <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (last_cnt) begin
                        r_base   <= n_p2;
                        r_mul_sh <= n_p2;
                        r_p2     <= '0;
                        r_state  <= (r_exp_sh == '0) ? S_FINISH : S_EXP;
                    end else begin
                        r_p2     <= n_p2;
                        r_mul_sh <= {r_mul_sh[WORD_WIDTH-2:0], 1'b0};
                    end
                end
                S_EXP: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (last_cnt) begin
                        if (r_exp_sh[0]) begin
                            r_acc <= n_p1;
                        end
                        r_base   <= n_p2;
                        r_mul_sh <= n_p2;
                        r_p1     <= '0;
                        r_p2     <= '0;
                        r_exp_sh <= r_exp_sh >> 1;
                        // Stop once no set exponent bit remains above this one.
                        if ((r_exp_sh >> 1) == '0) begin
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_p1     <= n_p1;
                        r_p2     <= n_p2;
                        r_mul_sh <= {r_mul_sh[WORD_WIDTH-2:0], 1'b0};
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_dec ? {{(WORD_WIDTH-8){1'b0}}, r_acc[7:0]} : r_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_partial_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP) |-> (r_p1 < r_mod) && (r_p2 < r_mod))
        else $error("partial product not reduced below modulus");

    a_acc_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP) |-> (r_acc < r_mod) && (r_base < r_mod))
        else $error("running result or base not reduced below modulus");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_FINISH))
        else $error("result word appeared without a finished item");

    a_zero_mod_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (r_cfg_mod == '0)) |=> (r_state == S_FINISH) && (r_acc == '0))
        else $error("zero modulus did not give an immediate zero result");

endmodule
